@@ design/crc32dp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32dp_pkg
// Shared types and constants of the dual-polynomial CRC-32 stream engine:
// polynomials, register map, queue word format and the per-count update
// matrices built at elaboration.
// ----------------------------------------------------------------------------
package crc32dp_pkg;

   localparam int BYTES_PER_ITEM = 4;
   localparam int DATA_W         = 32;
   localparam int CRC_W          = 32;
   localparam int CNT_W          = $clog2(BYTES_PER_ITEM + 1);
   localparam int LANES          = (BYTES_PER_ITEM < 4) ? BYTES_PER_ITEM : 4;

   localparam logic [CRC_W-1:0] POLY_IEEE_REFL   = 32'hEDB88320;
   localparam logic [CRC_W-1:0] POLY_CAST_NORMAL = 32'h1EDC6F41;
   localparam logic [CRC_W-1:0] POLY_CAST_REFL   = {<<{POLY_CAST_NORMAL}};
   localparam logic [CRC_W-1:0] ALL_ONES         = 32'hFFFFFFFF;
   localparam logic [7:0]       BYTE_MASK        = 8'hFF;

   // register map, word index taken from paddr[2]
   localparam int           PADDR_W       = 3;
   localparam logic         CSR_IDX_POLY  = 1'b0;
   localparam logic         CSR_IDX_SEED  = 1'b1;
   localparam logic         POLY_SEL_IEEE = 1'b0;

   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [CNT_W-1:0]  count;
      logic              first;
      logic              last;
      logic              poly;
      logic [CRC_W-1:0]  seed_inv;
   } item_type;

   // column j of [poly][count] is the register after count bytes of shifts
   // starting from bit j alone
   typedef logic [1:0][BYTES_PER_ITEM:0][CRC_W-1:0][CRC_W-1:0] crc_mat_type;

   function automatic crc_mat_type build_mat();
      crc_mat_type      m;
      logic [CRC_W-1:0] v;
      logic [CRC_W-1:0] poly;
      m = '0;
      for (int p = 0; p < 2; p++) begin
         poly = (p == 0) ? POLY_IEEE_REFL : POLY_CAST_REFL;
         for (int n = 0; n <= BYTES_PER_ITEM; n++) begin
            for (int j = 0; j < CRC_W; j++) begin
               v = '0;
               v[j] = 1'b1;
               for (int k = 0; k < 8 * n; k++) begin
                  v = v[0] ? ((v >> 1) ^ poly) : (v >> 1);
               end
               m[p][n][j] = v;
            end
         end
      end
      return m;
   endfunction

   localparam crc_mat_type CRC_MAT = build_mat();

endpackage
`default_nettype wire

@@ design/crc32_dual_poly_stream.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32_dual_poly_stream
// Reflected CRC-32 / CRC-32C stream engine with APB-style register port.
// ----------------------------------------------------------------------------
// One word of up to four bytes is taken every cycle while the two-entry queue
// has room; a message's CRC passes through the input queue and then the
// output register once its last word is accepted, and that last word stays
// queued while an earlier result waits unaccepted. The rate is set by the CRC
// register loop, which folds a whole word per cycle through one XOR matrix.
// Register 0 (byte 0x0) bit 0 selects CRC-32C when set, register 1 (byte 0x4)
// holds the seed loaded, inverted, on each first word. Both are latched with
// each word as it enters, so write them only with the block idle.
// ----------------------------------------------------------------------------
module crc32_dual_poly_stream (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [crc32dp_pkg::PADDR_W-1:0] paddr,
   input  wire logic [31:0]                     pwdata,
   output logic      [31:0]                     prdata,
   output logic                                 pready,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [31:0]                     req_data_word,
   input  wire logic [2:0]                      req_byte_count,
   input  wire logic                            req_first_item,
   input  wire logic                            req_last_item,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [31:0]                     rsp_crc_result
);

   crc32dp_pkg::item_type push_item;
   crc32dp_pkg::item_type pop_item;
   logic pop_valid, pop_ready;

   assign pready = 1'b1;

   crc32dp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_first_item (req_first_item),
      .req_last_item  (req_last_item),
      .push_item      (push_item)
   );

   crc32dp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   crc32dp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_item       (pop_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_crc_result (rsp_crc_result)
   );

endmodule
`default_nettype wire

@@ design/crc32dp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32dp_front
// Register file and input stage: takes words, clamps the byte count, clears
// unused byte lanes and tags each word with polynomial and seed.
// ----------------------------------------------------------------------------
module crc32dp_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [crc32dp_pkg::PADDR_W-1:0] paddr,
   input  wire logic [31:0]                     pwdata,
   output logic      [31:0]                     prdata,
   input  wire logic [31:0]                     req_data_word,
   input  wire logic [2:0]                      req_byte_count,
   input  wire logic                            req_first_item,
   input  wire logic                            req_last_item,
   output crc32dp_pkg::item_type                push_item
);

   logic        poly_ff, poly_in;
   logic [31:0] seed_ff, seed_in;
   logic        wr_en;
   logic [crc32dp_pkg::CNT_W-1:0] cnt;

   assign wr_en = psel && penable && pwrite;

   always_comb begin
      poly_in = poly_ff;
      seed_in = seed_ff;
      if (wr_en) begin
         case (paddr[2])
            crc32dp_pkg::CSR_IDX_POLY: poly_in = pwdata[0];
            crc32dp_pkg::CSR_IDX_SEED: seed_in = pwdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= crc32dp_pkg::POLY_SEL_IEEE;
         seed_ff <= '0;
      end else begin
         poly_ff <= poly_in;
         seed_ff <= seed_in;
      end
   end

   always_comb begin
      case (paddr[2])
         crc32dp_pkg::CSR_IDX_POLY: prdata = {31'd0, poly_ff};
         crc32dp_pkg::CSR_IDX_SEED: prdata = seed_ff;
         default:                   prdata = '0;
      endcase
   end

   always_comb begin
      if (int'(req_byte_count) > crc32dp_pkg::BYTES_PER_ITEM)
         cnt = crc32dp_pkg::CNT_W'(crc32dp_pkg::BYTES_PER_ITEM);
      else
         cnt = crc32dp_pkg::CNT_W'(req_byte_count);
   end

   always_comb begin
      push_item.data = '0;
      for (int i = 0; i < crc32dp_pkg::LANES; i++) begin
         if (i < int'(cnt))
            push_item.data[8*i +: 8] = req_data_word[8*i +: 8] & crc32dp_pkg::BYTE_MASK;
      end
      push_item.count    = cnt;
      push_item.first    = req_first_item;
      push_item.last     = req_last_item;
      push_item.poly     = poly_ff;
      push_item.seed_inv = seed_ff ^ crc32dp_pkg::ALL_ONES;
   end

endmodule
`default_nettype wire

@@ design/crc32dp_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32dp_queue
// Short FIFO between the input stage and the CRC engine.
// ----------------------------------------------------------------------------
module crc32dp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   output logic                       push_ready,
   input  wire crc32dp_pkg::item_type push_item,
   output logic                       pop_valid,
   input  wire logic                  pop_ready,
   output crc32dp_pkg::item_type      pop_item
);

   crc32dp_pkg::item_type mem_ff [crc32dp_pkg::QUEUE_DEPTH];
   logic [crc32dp_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [crc32dp_pkg::Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [crc32dp_pkg::Q_CNT_W-1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign push_ready = (cnt_ff != crc32dp_pkg::Q_CNT_W'(crc32dp_pkg::QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == crc32dp_pkg::Q_PTR_W'(crc32dp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == crc32dp_pkg::Q_PTR_W'(crc32dp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)
         cnt_in = cnt_ff + 1'b1;
      else if (pop && !push)
         cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_item;
   end

endmodule
`default_nettype wire

@@ design/crc32dp_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32dp_back
// CRC engine: folds one queued word into the running CRC per cycle through an
// XOR matrix; a last word waits for room in the result output register.
// ----------------------------------------------------------------------------
module crc32dp_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pop_valid,
   output logic                       pop_ready,
   input  wire crc32dp_pkg::item_type pop_item,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [31:0]                rsp_crc_result
);

   logic [crc32dp_pkg::CRC_W-1:0] crc_ff, crc_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [crc32dp_pkg::CRC_W-1:0] rsp_crc_ff, rsp_crc_in;
   logic [crc32dp_pkg::CRC_W-1:0] x;
   logic [crc32dp_pkg::CRC_W-1:0] next_crc;
   logic [crc32dp_pkg::CRC_W-1:0][crc32dp_pkg::CRC_W-1:0] mat;
   logic pop;

   assign pop_ready = !pop_item.last || !rsp_valid_ff || rsp_ready;
   assign pop       = pop_valid && pop_ready;

   // bytes are xored in first, then count*8 shift steps as one linear map
   always_comb begin
      x        = (pop_item.first ? pop_item.seed_inv : crc_ff) ^ pop_item.data;
      mat      = crc32dp_pkg::CRC_MAT[pop_item.poly][pop_item.count];
      next_crc = '0;
      for (int j = 0; j < crc32dp_pkg::CRC_W; j++) begin
         if (x[j])
            next_crc = next_crc ^ mat[j];
      end
   end

   always_comb begin
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_crc_in   = rsp_crc_ff;
      if (pop) begin
         crc_in = next_crc;
         if (pop_item.last) begin
            rsp_valid_in = 1'b1;
            rsp_crc_in   = next_crc ^ crc32dp_pkg::ALL_ONES;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= crc32dp_pkg::ALL_ONES;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_crc_ff <= rsp_crc_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_crc_result = rsp_crc_ff;

endmodule
`default_nettype wire

@@ design/crc32dp_sva.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc32dp_sva
// Port-level checks of the CRC stream engine, bound to the top level.
// ----------------------------------------------------------------------------
module crc32dp_sva (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        pready,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_last_item,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_crc_result
);

   // words with last set taken but whose result is not yet delivered
   logic [2:0] pend_ff, pend_in;
   logic       take_last, give;

   assign take_last = req_valid && req_ready && req_last_item;
   assign give      = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (take_last && !give)
         pend_in = pend_ff + 1'b1;
      else if (give && !take_last)
         pend_in = pend_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_crc_result))
      else $error("result dropped or changed while stalled");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 3'd0)
      else $error("result without a pending last word");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready deasserted");

endmodule

bind crc32_dual_poly_stream crc32dp_sva u_sva (.*);
`default_nettype wire
